// ----- hw/rtl/linear_to_srgb_encoder_assert.svh -----
// Assertion macros shared by the sRGB encoder RTL.
`ifndef LINEAR_TO_SRGB_ENCODER_ASSERT_SVH
`define LINEAR_TO_SRGB_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define L2S_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("l2s assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define L2S_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("l2s assertion failed");

`endif

// ----- hw/rtl/l2s_pkg.sv -----
// Package with the types, constants and per-digit step functions of the sRGB encoder.
package l2s_pkg;

   localparam int LANE_COUNT    = 4;
   localparam int FRACTION_BITS = 16;
   localparam int IN_WIDTH      = FRACTION_BITS + 4;
   localparam int OUT_WIDTH     = FRACTION_BITS + 1;

   localparam int U_WIDTH    = 32;
   localparam int ROOT2_BITS = 32;
   localparam int ROOT3_BITS = 21;
   localparam int ACC_WIDTH  = 66;
   localparam int CBRT_SHIFT = 31;
   localparam int POW_FRAC   = 42;
   localparam int POW_SHIFT  = POW_FRAC - FRACTION_BITS;
   localparam int PROD_WIDTH = 54;

   localparam int DIVISOR    = 1000;
   localparam int POW_GAIN   = 1055;
   localparam int POW_OFFSET = 55;
   localparam int LIN_SCALE  = 12920;
   localparam int LIN_BIAS   = DIVISOR / 2;
   localparam int TWIDTH     = FRACTION_BITS + 11;

   // Reciprocal of the divisor: ceil(2^37 / 1000). The rounding error times any
   // TWIDTH-bit dividend stays below 2^37, so the quotient is exact.
   localparam int RECIP_MULT  = 137438954;
   localparam int RECIP_SHIFT = 37;
   localparam int RECIP_WIDTH = TWIDTH + 28;

   localparam longint LINEAR_LIMIT = (64'd31308 << FRACTION_BITS) / 64'd10000000;
   localparam logic [OUT_WIDTH-1:0] ONE_RAW = OUT_WIDTH'(1) << FRACTION_BITS;

   // Stage counts inside one lane, from the input register to the quotient register.
   localparam int LANE_STAGES = 1 + 2 * ROOT2_BITS + ROOT3_BITS + 3;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] lane3_linear;
      logic signed [IN_WIDTH-1:0] lane2_linear;
      logic signed [IN_WIDTH-1:0] lane1_linear;
      logic signed [IN_WIDTH-1:0] lane0_linear;
   } l2s_req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] lane3_encoded;
      logic [OUT_WIDTH-1:0] lane2_encoded;
      logic [OUT_WIDTH-1:0] lane1_encoded;
      logic [OUT_WIDTH-1:0] lane0_encoded;
   } l2s_rsp_type;

   typedef struct packed {
      logic                 neg;
      logic                 one;
      logic                 lin;
      logic [U_WIDTH-1:0]   u;
      logic [TWIDTH-1:0]    tl;
   } l2s_side_type;

   typedef struct packed {
      logic [ACC_WIDTH-1:0]  rem;
      logic [ROOT2_BITS-1:0] root;
   } l2s_sqrt_type;

   typedef struct packed {
      logic [ACC_WIDTH-1:0]    rem;
      logic [ROOT3_BITS-1:0]   root;
      logic [2*ROOT3_BITS-1:0] sq;
   } l2s_cbrt_type;

   // One bit of a square root; rem holds the operand minus the square of the root so far.
   function automatic l2s_sqrt_type sqrt_step(l2s_sqrt_type cur, int b);
      l2s_sqrt_type nxt;
      logic [ACC_WIDTH-1:0] trial;
      nxt   = cur;
      trial = (ACC_WIDTH'(cur.root) << (b + 1)) | (ACC_WIDTH'(1) << (2 * b));
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.root = cur.root | (ROOT2_BITS'(1) << b);
      end
      return nxt;
   endfunction

   // One bit of a cube root; the square of the root is kept so no multiplier is needed.
   function automatic l2s_cbrt_type cbrt_step(l2s_cbrt_type cur, int b);
      l2s_cbrt_type nxt;
      logic [ACC_WIDTH-1:0] t1;
      logic [ACC_WIDTH-1:0] t2;
      logic [ACC_WIDTH-1:0] trial;
      nxt   = cur;
      t1    = ACC_WIDTH'(cur.sq) << b;
      t2    = ACC_WIDTH'(cur.root) << (2 * b);
      trial = t1 + (t1 << 1) + t2 + (t2 << 1) + (ACC_WIDTH'(1) << (3 * b));
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.sq   = cur.sq + ((2 * ROOT3_BITS)'(cur.root) << (b + 1))
                    + ((2 * ROOT3_BITS)'(1) << (2 * b));
         nxt.root = cur.root | (ROOT3_BITS'(1) << b);
      end
      return nxt;
   endfunction

endpackage

// ----- hw/rtl/l2s_lane.sv -----
// One encoder lane: clamp, two square roots, two cube roots, product and constant division.
module l2s_lane (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [l2s_pkg::IN_WIDTH-1:0]  linear,
   output logic [l2s_pkg::OUT_WIDTH-1:0]        encoded
);

   localparam int FB  = l2s_pkg::FRACTION_BITS;
   localparam int R2  = l2s_pkg::ROOT2_BITS;
   localparam int R3  = l2s_pkg::ROOT3_BITS;
   localparam int ACC = l2s_pkg::ACC_WIDTH;
   localparam int TW  = l2s_pkg::TWIDTH;
   localparam int PW  = l2s_pkg::PROD_WIDTH;
   localparam int RW  = l2s_pkg::RECIP_WIDTH;

   // Input register with clamp classification.
   l2s_pkg::l2s_side_type side0_ff;
   l2s_pkg::l2s_side_type side0_in;
   logic [FB-1:0]         mant;
   logic                  above_one;

   always_comb begin
      mant           = linear[FB-1:0];
      above_one      = |linear[l2s_pkg::IN_WIDTH-2:FB];
      side0_in.neg   = linear[l2s_pkg::IN_WIDTH-1];
      side0_in.one   = !linear[l2s_pkg::IN_WIDTH-1] && above_one;
      side0_in.lin   = !above_one && (64'(mant) <= 64'(l2s_pkg::LINEAR_LIMIT));
      side0_in.u     = {mant, {(l2s_pkg::U_WIDTH - FB){1'b0}}};
      side0_in.tl    = TW'(mant) * TW'(l2s_pkg::LIN_SCALE) + TW'(l2s_pkg::LIN_BIAS);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side0_ff <= side0_in;
      end
   end

   // First square root: v^(1/2).
   l2s_pkg::l2s_sqrt_type s1_ff   [R2];
   l2s_pkg::l2s_side_type side1_ff [R2];

   for (genvar k = 0; k < R2; k++) begin : g_sqrt1
      l2s_pkg::l2s_sqrt_type src;
      l2s_pkg::l2s_side_type srcs;
      l2s_pkg::l2s_sqrt_type s1_in;
      if (k == 0) begin : g_first
         assign src.rem  = ACC'(side0_ff.u) << R2;
         assign src.root = '0;
         assign srcs     = side0_ff;
      end else begin : g_next
         assign src  = s1_ff[k-1];
         assign srcs = side1_ff[k-1];
      end
      assign s1_in = l2s_pkg::sqrt_step(src, R2 - 1 - k);
      always_ff @(posedge clock) begin
         if (advance) begin
            s1_ff[k]    <= s1_in;
            side1_ff[k] <= srcs;
         end
      end
   end

   // Second square root: v^(1/4).
   l2s_pkg::l2s_sqrt_type s2_ff   [R2];
   l2s_pkg::l2s_side_type side2_ff [R2];

   for (genvar k = 0; k < R2; k++) begin : g_sqrt2
      l2s_pkg::l2s_sqrt_type src;
      l2s_pkg::l2s_side_type srcs;
      l2s_pkg::l2s_sqrt_type s2_in;
      if (k == 0) begin : g_first
         assign src.rem  = ACC'(s1_ff[R2-1].root) << R2;
         assign src.root = '0;
         assign srcs     = side1_ff[R2-1];
      end else begin : g_next
         assign src  = s2_ff[k-1];
         assign srcs = side2_ff[k-1];
      end
      assign s2_in = l2s_pkg::sqrt_step(src, R2 - 1 - k);
      always_ff @(posedge clock) begin
         if (advance) begin
            s2_ff[k]    <= s2_in;
            side2_ff[k] <= srcs;
         end
      end
   end

   // Cube roots side by side: v^(1/12) from the fourth root and v^(1/3) from the sample.
   l2s_pkg::l2s_cbrt_type ca_ff   [R3];
   l2s_pkg::l2s_cbrt_type cb_ff   [R3];
   l2s_pkg::l2s_side_type side3_ff [R3];

   for (genvar k = 0; k < R3; k++) begin : g_cbrt
      l2s_pkg::l2s_cbrt_type srca;
      l2s_pkg::l2s_cbrt_type srcb;
      l2s_pkg::l2s_side_type srcs;
      l2s_pkg::l2s_cbrt_type ca_in;
      l2s_pkg::l2s_cbrt_type cb_in;
      if (k == 0) begin : g_first
         assign srca.rem  = ACC'(s2_ff[R2-1].root) << l2s_pkg::CBRT_SHIFT;
         assign srca.root = '0;
         assign srca.sq   = '0;
         assign srcb.rem  = ACC'(side2_ff[R2-1].u) << l2s_pkg::CBRT_SHIFT;
         assign srcb.root = '0;
         assign srcb.sq   = '0;
         assign srcs      = side2_ff[R2-1];
      end else begin : g_next
         assign srca = ca_ff[k-1];
         assign srcb = cb_ff[k-1];
         assign srcs = side3_ff[k-1];
      end
      assign ca_in = l2s_pkg::cbrt_step(srca, R3 - 1 - k);
      assign cb_in = l2s_pkg::cbrt_step(srcb, R3 - 1 - k);
      always_ff @(posedge clock) begin
         if (advance) begin
            ca_ff[k]    <= ca_in;
            cb_ff[k]    <= cb_in;
            side3_ff[k] <= srcs;
         end
      end
   end

   // Product v^(5/12) in Q42.
   logic [2*R3-1:0]       y_ff;
   logic [2*R3-1:0]       y_in;
   l2s_pkg::l2s_side_type side4_ff;

   assign y_in = (2*R3)'(ca_ff[R3-1].root) * (2*R3)'(cb_ff[R3-1].root);

   always_ff @(posedge clock) begin
      if (advance) begin
         y_ff     <= y_in;
         side4_ff <= side3_ff[R3-1];
      end
   end

   // Dividend for the constant divider; the linear segment is scaled to share it.
   logic [TW-1:0]         t_ff;
   logic [TW-1:0]         t_in;
   logic [PW-1:0]         prod;
   logic [PW-1:0]         numer;
   l2s_pkg::l2s_side_type side5_ff;

   always_comb begin
      prod  = PW'(y_ff) * PW'(l2s_pkg::POW_GAIN);
      numer = prod - (PW'(l2s_pkg::POW_OFFSET) << l2s_pkg::POW_FRAC)
              + (PW'(l2s_pkg::DIVISOR) << (l2s_pkg::POW_SHIFT - 1));
      t_in  = side4_ff.lin ? side4_ff.tl : numer[l2s_pkg::POW_SHIFT +: TW];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_ff     <= t_in;
         side5_ff <= side4_ff;
      end
   end

   // Division by the constant divisor as one multiplication by its scaled reciprocal.
   logic [RW-1:0]                 recip_prod;
   logic [l2s_pkg::OUT_WIDTH-1:0] quo_ff;
   logic [l2s_pkg::OUT_WIDTH-1:0] quo_in;
   l2s_pkg::l2s_side_type         side6_ff;

   always_comb begin
      recip_prod = RW'(t_ff) * RW'(l2s_pkg::RECIP_MULT);
      quo_in     = recip_prod[l2s_pkg::RECIP_SHIFT +: l2s_pkg::OUT_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff   <= quo_in;
         side6_ff <= side5_ff;
      end
   end

   always_comb begin
      if (side6_ff.neg) begin
         encoded = '0;
      end else if (side6_ff.one || (quo_ff > l2s_pkg::ONE_RAW)) begin
         encoded = l2s_pkg::ONE_RAW;
      end else begin
         encoded = quo_ff;
      end
   end

endmodule

// ----- hw/rtl/l2s_merge.sv -----
// Output register that gathers the lane results into one result transaction.
module l2s_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic [l2s_pkg::OUT_WIDTH-1:0]      lane_encoded [l2s_pkg::LANE_COUNT],
   output logic                               rsp_valid,
   output l2s_pkg::l2s_rsp_type               rsp_payload
);

   logic                 valid_ff;
   l2s_pkg::l2s_rsp_type payload_ff;
   l2s_pkg::l2s_rsp_type payload_in;

   always_comb begin
      payload_in.lane0_encoded = lane_encoded[0];
      payload_in.lane1_encoded = lane_encoded[1];
      payload_in.lane2_encoded = lane_encoded[2];
      payload_in.lane3_encoded = lane_encoded[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         payload_ff <= payload_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

// ----- hw/rtl/linear_to_srgb_encoder.sv -----
// Top level of the four-lane linear to sRGB encoder.
// Each transaction carries four signed Q16 linear samples; each lane clamps its sample to
// [0,1] and applies the sRGB curve, linear below the threshold and 1.055*v^(1/2.4)-0.055
// above it, with the power built from two square roots, two cube roots and one product.
// A transaction is accepted every cycle unless the result side stalls; its result passes through
// one input register, 64 square-root bit stages, 21 cube-root bit stages, a product stage,
// a dividend stage, a reciprocal-multiply stage for the divide by 1000 and the output
// register. A stall on the result side holds the whole pipeline, so req_stall follows
// rsp_stall while a result is waiting.
`include "linear_to_srgb_encoder_assert.svh"

module linear_to_srgb_encoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  l2s_pkg::l2s_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output l2s_pkg::l2s_rsp_type  rsp_payload
);

   localparam int LS = l2s_pkg::LANE_STAGES;

   logic                                advance;
   logic [LS-1:0]                       vld_ff;
   logic signed [l2s_pkg::IN_WIDTH-1:0] lane_linear  [l2s_pkg::LANE_COUNT];
   logic [l2s_pkg::OUT_WIDTH-1:0]       lane_encoded [l2s_pkg::LANE_COUNT];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   assign lane_linear[0] = req_payload.lane0_linear;
   assign lane_linear[1] = req_payload.lane1_linear;
   assign lane_linear[2] = req_payload.lane2_linear;
   assign lane_linear[3] = req_payload.lane3_linear;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[LS-2:0], req_valid};
      end
   end

   for (genvar l = 0; l < l2s_pkg::LANE_COUNT; l++) begin : g_lane
      l2s_lane u_lane (
         .clock   (clock),
         .advance (advance),
         .linear  (lane_linear[l]),
         .encoded (lane_encoded[l])
      );
   end

   l2s_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (vld_ff[LS-1]),
      .lane_encoded (lane_encoded),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

   `L2S_ASSERT_SAME(a_stall_only_when_blocked, clock, reset, req_stall, rsp_valid && rsp_stall)
   `L2S_ASSERT_SAME(a_lane0_in_range, clock, reset, rsp_valid, rsp_payload.lane0_encoded <= l2s_pkg::ONE_RAW)
   `L2S_ASSERT_NEXT(a_pipe_holds_on_stall, clock, reset, req_stall, $stable(vld_ff))

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the four-lane linear to sRGB encoder.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_START = 600;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   l2s_pkg::l2s_req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   l2s_pkg::l2s_rsp_type rsp_payload;

   l2s_pkg::l2s_rsp_type pending_encodings[$];
   int error_count = 0;
   int cycle_count = 0;
   int hold_count = 0;
   int stall_left = 0;
   bit feeding_done = 1'b0;
   bit hold_done = 1'b0;

   linear_to_srgb_encoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] floor_cbrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c * c <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic [l2s_pkg::OUT_WIDTH-1:0] srgb_encode(
      logic [l2s_pkg::IN_WIDTH-1:0] raw);
      logic [63:0] m, u, s, q, a12, a3, y, num, den;
      m = 64'(raw);
      if (raw[l2s_pkg::IN_WIDTH-1]) return '0;
      if (m >= (64'd1 << l2s_pkg::FRACTION_BITS)) return l2s_pkg::ONE_RAW;
      if (m <= 64'(l2s_pkg::LINEAR_LIMIT))
         return l2s_pkg::OUT_WIDTH'((m * 646 + 25) / 50);
      u = m << (32 - l2s_pkg::FRACTION_BITS);
      s = floor_sqrt(u << 32);
      q = floor_sqrt(s << 32);
      a12 = floor_cbrt(q << 31);
      a3 = floor_cbrt(u << 31);
      y = a3 * a12;
      num = 64'd1055 * y - (64'd55 << 42);
      den = 64'd1000 << (42 - l2s_pkg::FRACTION_BITS);
      num = (num + den / 2) / den;
      if (num > 64'(l2s_pkg::ONE_RAW)) num = 64'(l2s_pkg::ONE_RAW);
      return l2s_pkg::OUT_WIDTH'(num);
   endfunction

   function automatic l2s_pkg::l2s_rsp_type encode_pixel(l2s_pkg::l2s_req_type p);
      l2s_pkg::l2s_rsp_type r;
      r.lane0_encoded = srgb_encode(p.lane0_linear);
      r.lane1_encoded = srgb_encode(p.lane1_linear);
      r.lane2_encoded = srgb_encode(p.lane2_linear);
      r.lane3_encoded = srgb_encode(p.lane3_linear);
      return r;
   endfunction

   // Mostly in-range samples near the curve, some around the threshold, some wild.
   function automatic logic [l2s_pkg::IN_WIDTH-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return l2s_pkg::IN_WIDTH'($urandom_range(0, 65536));
      if (pick < 7) return l2s_pkg::IN_WIDTH'($urandom_range(190, 225));
      if (pick < 8) return l2s_pkg::IN_WIDTH'($urandom_range(0, 4095));
      return l2s_pkg::IN_WIDTH'($urandom);
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_pixel(l2s_pkg::l2s_req_type p, l2s_pkg::l2s_rsp_type want, bit typed);
      int gap;
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      pending_encodings.push_back(typed ? want : encode_pixel(p));
      gap = random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   typedef struct {
      l2s_pkg::l2s_req_type pixel;
      bit typed;
      l2s_pkg::l2s_rsp_type want;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic l2s_pkg::l2s_req_type same_lanes(logic [l2s_pkg::IN_WIDTH-1:0] v);
      return {v, v, v, v};
   endfunction

   function automatic l2s_pkg::l2s_rsp_type same_codes(logic [l2s_pkg::OUT_WIDTH-1:0] v);
      return {v, v, v, v};
   endfunction

   // Stimulus process.
   initial begin
      l2s_pkg::l2s_req_type p;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      directed_rows.push_back('{same_lanes(20'd0), 1'b1, same_codes(17'd0)});
      directed_rows.push_back('{same_lanes(20'h80000), 1'b1, same_codes(17'd0)});
      directed_rows.push_back('{same_lanes(20'hFFFFF), 1'b1, same_codes(17'd0)});
      directed_rows.push_back('{same_lanes(20'h7FFFF), 1'b1, same_codes(l2s_pkg::ONE_RAW)});
      directed_rows.push_back('{same_lanes(20'd65536), 1'b1, same_codes(l2s_pkg::ONE_RAW)});
      directed_rows.push_back('{same_lanes(20'd65537), 1'b1, same_codes(l2s_pkg::ONE_RAW)});
      directed_rows.push_back('{same_lanes(20'd1), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'd204), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'd205), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'd206), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'd207), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'd65535), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'd32768), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'h55555), 1'b0, '0});
      directed_rows.push_back('{same_lanes(20'hAAAAA), 1'b0, '0});
      directed_rows.push_back('{{20'hFFFFF, 20'd65535, 20'd205, 20'd0}, 1'b0, '0});
      foreach (directed_rows[i])
         send_pixel(directed_rows[i].pixel, directed_rows[i].want, directed_rows[i].typed);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         p.lane0_linear = random_sample();
         p.lane1_linear = random_sample();
         p.lane2_linear = random_sample();
         p.lane3_linear = random_sample();
         send_pixel(p, '0, 1'b0);
      end
      req_valid <= 1'b0;
      feeding_done = 1'b1;
   end

   // Result side: random stall runs plus one long hold-off that fills the pipeline.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!hold_done && cycle_count > HOLD_START) begin
         if (hold_count < HOLD_CYCLES) begin
            hold_count++;
            rsp_stall <= 1'b1;
         end else begin
            hold_done = 1'b1;
            rsp_stall <= 1'b0;
         end
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left = random_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // A transaction on the result side is compared with the oldest expectation.
   always @(posedge clock) begin
      l2s_pkg::l2s_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_encodings.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            error_count++;
         end else begin
            want = pending_encodings.pop_front();
            if (rsp_payload.lane0_encoded !== want.lane0_encoded)
               $display("%0t: lane0 expected %0d actual %0d", $time,
                        want.lane0_encoded, rsp_payload.lane0_encoded);
            if (rsp_payload.lane1_encoded !== want.lane1_encoded)
               $display("%0t: lane1 expected %0d actual %0d", $time,
                        want.lane1_encoded, rsp_payload.lane1_encoded);
            if (rsp_payload.lane2_encoded !== want.lane2_encoded)
               $display("%0t: lane2 expected %0d actual %0d", $time,
                        want.lane2_encoded, rsp_payload.lane2_encoded);
            if (rsp_payload.lane3_encoded !== want.lane3_encoded)
               $display("%0t: lane3 expected %0d actual %0d", $time,
                        want.lane3_encoded, rsp_payload.lane3_encoded);
            if (rsp_payload !== want) error_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      wait (feeding_done);
      while (pending_encodings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_encodings.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
